[rtl/qsort_pkg.sv]
// Package for the quicksort block: constants, controller state type and
// the command/status structs between controller and datapath. No dependencies.
package qsort_pkg;

  localparam int unsigned MAX_ELEM_DEF = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned CNT_W        = 11;

  localparam logic [1:0] RULE_FIRST  = 2'd0;
  localparam logic [1:0] RULE_LAST   = 2'd1;
  localparam logic [1:0] RULE_MEDIAN = 2'd2;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_POP,
    ST_RD_POP,
    ST_RANGE,
    ST_MED_A,
    ST_MED_B,
    ST_MED_C,
    ST_MED_SEL,
    ST_SWP_RD,
    ST_SWP_W1,
    ST_SWP_W2,
    ST_PIV_RD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SHOW
  } qsort_state_t;

  // swap return points
  typedef enum logic [1:0] {
    RET_PIVOT,
    RET_SCAN,
    RET_FINAL
  } qsort_ret_t;

  typedef enum logic [1:0] {
    ADR_A,
    ADR_B,
    ADR_IDX
  } qsort_asel_t;

  typedef struct packed {
    logic        mem_rd;      // read element at selected address
    qsort_asel_t rd_sel;
    logic        mem_wr;      // write element
    qsort_asel_t wr_sel;
    logic        wr_from_a;   // write data = latched A (else latched B)
    logic        lat_a;       // latch read data into A
    logic        lat_b;
    logic        lat_c;
    logic        lat_piv;
  } qsort_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] c;
    logic             rd_lt_piv;  // last read element < pivot
    logic [VAL_W-1:0] rd_data;
  } qsort_sts_t;

  function automatic logic lts(input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

endpackage

[rtl/qsort_dp.sv]
// Datapath of the quicksort block: element memory with registered read,
// latches for median and swap operands, pivot compare. Uses qsort_pkg.
module qsort_dp #(
  parameter int unsigned MAX_ELEMENTS = qsort_pkg::MAX_ELEM_DEF
) (
  input  logic                         clk,
  input  logic                         wr_load,
  input  logic [5:0]                   load_adr,
  input  logic [qsort_pkg::VAL_W-1:0]  load_data,
  input  qsort_pkg::qsort_cmd_t        cmd,
  input  logic [5:0]                   adr_a,
  input  logic [5:0]                   adr_b,
  input  logic [5:0]                   adr_idx,
  output qsort_pkg::qsort_sts_t        sts
);
  import qsort_pkg::*;

  logic [VAL_W-1:0] mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] rd_r, a_r, b_r, c_r, piv_r;
  logic [5:0]       rd_adr, wr_adr;
  logic [VAL_W-1:0] wr_data;

  always_comb begin
    case (cmd.rd_sel)
      ADR_A:   rd_adr = adr_a;
      ADR_B:   rd_adr = adr_b;
      default: rd_adr = adr_idx;
    endcase
    case (cmd.wr_sel)
      ADR_A:   wr_adr = adr_a;
      ADR_B:   wr_adr = adr_b;
      default: wr_adr = adr_idx;
    endcase
    wr_data = cmd.wr_from_a ? a_r : b_r;
  end

  always_ff @(posedge clk) begin
    if (wr_load) begin
      mem[load_adr] <= load_data;
    end else if (cmd.mem_wr) begin
      mem[wr_adr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[rd_adr];
    end
    if (cmd.lat_a) a_r <= rd_r;
    if (cmd.lat_b) b_r <= rd_r;
    if (cmd.lat_c) c_r <= rd_r;
    if (cmd.lat_piv) piv_r <= rd_r;
  end

  assign sts.a         = a_r;
  assign sts.b         = b_r;
  assign sts.c         = c_r;
  assign sts.rd_data   = rd_r;
  assign sts.rd_lt_piv = lts(rd_r, piv_r);

endmodule

[rtl/qsort_ctrl.sv]
// Controller of the quicksort block: load, range stack, pivot selection,
// partition scan and result output. Uses qsort_pkg; drives qsort_dp.
module qsort_ctrl #(
  parameter int unsigned MAX_ELEMENTS = qsort_pkg::MAX_ELEM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_pivot_rule,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_last,
  output logic                         wr_load,
  output logic [5:0]                   load_adr,
  output qsort_pkg::qsort_cmd_t        cmd,
  output logic [5:0]                   adr_a,
  output logic [5:0]                   adr_b,
  output logic [5:0]                   adr_idx,
  input  qsort_pkg::qsort_sts_t        sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [qsort_pkg::VAL_W-1:0]  out_sorted_value,
  output logic [qsort_pkg::POS_W-1:0]  out_position,
  output logic [qsort_pkg::CNT_W-1:0]  out_comparisons,
  output logic                         out_final_result
);
  import qsort_pkg::*;

  localparam int unsigned MAX7 = MAX_ELEMENTS;

  qsort_state_t st_r, st_nxt;
  qsort_ret_t   ret_r, ret_nxt;
  logic [1:0]   rule_r;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [6:0]   sp_r, sp_nxt;
  logic [CNT_W-1:0] cmp_r, cmp_nxt;
  logic [5:0]   s_r, s_nxt;
  logic [6:0]   n_r, n_nxt;
  logic [6:0]   i_r, i_nxt;
  logic [6:0]   j_r, j_nxt;
  logic [5:0]   pa_r, pa_nxt, pb_r, pb_nxt, pm_r, pm_nxt, pl_r, pl_nxt;
  logic [5:0]   k_r, k_nxt;
  logic [12:0]  stk [64];
  logic [12:0]  stk_rd_r;
  logic         stk_we;
  logic [12:0]  stk_wd;
  logic [5:0]   stk_wa;
  logic         ov_r, ov_nxt;
  logic [VAL_W-1:0] ov_val_r, ov_val_nxt;
  logic [POS_W-1:0] ov_pos_r, ov_pos_nxt;
  logic [CNT_W-1:0] ov_cmp_r, ov_cmp_nxt;
  logic         ov_fin_r, ov_fin_nxt;
  logic         accept;
  logic         med_a, med_b;
  logic [6:0]   lenr;

  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != ST_LOAD);
  assign wr_load = accept && (cnt_r < MAX7);
  assign load_adr = cnt_r[5:0];
  assign adr_a = pa_r;
  assign adr_b = pb_r;
  assign adr_idx = k_r;

  assign out_valid = ov_r;
  assign out_sorted_value = ov_val_r;
  assign out_position = ov_pos_r;
  assign out_final_result = ov_fin_r;
  assign out_comparisons = ov_cmp_r;

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_rd_r <= stk[sp_r[5:0] - 6'd1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      rule_r <= RULE_MEDIAN;
      cnt_r <= '0;
      sp_r <= '0;
      cmp_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) rule_r <= (cfg_pivot_rule == 2'd3) ? RULE_MEDIAN : cfg_pivot_rule;
      cnt_r <= cnt_nxt;
      sp_r <= sp_nxt;
      cmp_r <= cmp_nxt;
      ov_r <= ov_nxt;
    end
    ret_r <= ret_nxt;
    s_r <= s_nxt; n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; pm_r <= pm_nxt; pl_r <= pl_nxt;
    k_r <= k_nxt;
    ov_val_r <= ov_val_nxt; ov_pos_r <= ov_pos_nxt; ov_fin_r <= ov_fin_nxt;
    ov_cmp_r <= ov_cmp_nxt;
  end

  always_comb begin
    med_a = (!lts(sts.a, sts.b) || !lts(sts.a, sts.c)) &&
            (!lts(sts.b, sts.a) || !lts(sts.c, sts.a));
    med_b = (!lts(sts.b, sts.a) || !lts(sts.b, sts.c)) &&
            (!lts(sts.a, sts.b) || !lts(sts.c, sts.b));
    lenr = n_r - i_r - 7'd1;
  end

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r;
    cnt_nxt = cnt_r; sp_nxt = sp_r; cmp_nxt = cmp_r;
    s_nxt = s_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r;
    pa_nxt = pa_r; pb_nxt = pb_r; pm_nxt = pm_r; pl_nxt = pl_r; k_nxt = k_r;
    ov_nxt = ov_r; ov_val_nxt = ov_val_r; ov_pos_nxt = ov_pos_r; ov_fin_nxt = ov_fin_r;
    ov_cmp_nxt = ov_cmp_r;
    stk_we = 1'b0; stk_wd = '0; stk_wa = sp_r[5:0];
    cmd = '0;
    cmd.rd_sel = ADR_IDX;
    cmd.wr_sel = ADR_IDX;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < MAX7) cnt_nxt = cnt_r + 7'd1;
          if (in_last) begin
            cmp_nxt = '0;
            sp_nxt = '0;
            if (((cnt_r < MAX7) ? cnt_r + 7'd1 : cnt_r) > 7'd1) begin
              stk_we = 1'b1; stk_wa = 6'd0;
              stk_wd = {((cnt_r < MAX7) ? cnt_r + 7'd1 : cnt_r), 6'd0};
              sp_nxt = 7'd1;
            end
            st_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (sp_r == 7'd0) begin
          k_nxt = '0;
          st_nxt = ST_OUT_RD;
        end else begin
          st_nxt = ST_RD_POP;
        end
      end
      ST_RD_POP: begin
        s_nxt = stk_rd_r[5:0];
        n_nxt = stk_rd_r[12:6];
        sp_nxt = sp_r - 7'd1;
        st_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        if (n_r < 7'd2 || ({1'b0, s_r} + n_r) > cnt_r) begin
          st_nxt = ST_POP;
        end else begin
          cmp_nxt = cmp_r + CNT_W'(n_r - 7'd1);
          pl_nxt = 6'(s_r + n_r - 7'd1);
          pm_nxt = 6'(s_r + ((n_r + 7'd1) >> 1) - 7'd1);
          pa_nxt = s_r;
          j_nxt = 7'd0;
          case (rule_r)
            RULE_FIRST: begin
              k_nxt = s_r;
              st_nxt = ST_PIV_RD;
            end
            RULE_LAST: begin
              pb_nxt = 6'(s_r + n_r - 7'd1);
              ret_nxt = RET_PIVOT;
              st_nxt = ST_SWP_RD;
            end
            default: begin
              k_nxt = s_r;
              st_nxt = ST_MED_A;
            end
          endcase
        end
      end
      ST_MED_A: begin
        cmd.mem_rd = 1'b1; k_nxt = pm_r;
        st_nxt = ST_MED_B;
      end
      ST_MED_B: begin
        cmd.mem_rd = 1'b1; cmd.lat_a = 1'b1; k_nxt = pl_r;
        st_nxt = ST_MED_C;
      end
      ST_MED_C: begin
        cmd.mem_rd = 1'b1; cmd.lat_b = 1'b1;
        st_nxt = ST_MED_SEL;
      end
      ST_MED_SEL: begin
        cmd.lat_c = 1'b1;
        st_nxt = ST_MED_SEL;
        if (j_r == 7'd0) begin
          j_nxt = 7'd1;
        end else begin
          j_nxt = 7'd0;
          pb_nxt = med_a ? s_r : (med_b ? pm_r : pl_r);
          ret_nxt = RET_PIVOT;
          st_nxt = ST_SWP_RD;
        end
      end
      ST_SWP_RD: begin
        cmd.mem_rd = 1'b1; cmd.rd_sel = ADR_A;
        j_nxt = 7'd0;
        st_nxt = ST_SWP_W1;
      end
      ST_SWP_W1: begin
        if (j_r == 7'd0) begin
          cmd.mem_rd = 1'b1; cmd.rd_sel = ADR_B; cmd.lat_a = 1'b1;
          j_nxt = 7'd1;
        end else begin
          cmd.lat_b = 1'b1;
          st_nxt = ST_SWP_W2;
        end
      end
      ST_SWP_W2: begin
        cmd.mem_wr = 1'b1; cmd.wr_sel = ADR_A; cmd.wr_from_a = 1'b0;
        st_nxt = ST_SWP_W2;
        if (j_r == 7'd1) begin
          j_nxt = 7'd2;
        end else begin
          cmd.wr_sel = ADR_B; cmd.wr_from_a = 1'b1;
          case (ret_r)
            RET_PIVOT: begin
              k_nxt = s_r; j_nxt = 7'd0; st_nxt = ST_PIV_RD;
            end
            RET_SCAN: begin
              i_nxt = i_r + 7'd1; j_nxt = pm_r + 7'd1;
              st_nxt = ST_SCAN_RD;
            end
            default: begin
              st_nxt = ST_PUSH_R;
            end
          endcase
          if (ret_r == RET_SCAN) j_nxt = {1'b0, pm_r} + 7'd1;
        end
        if (j_r == 7'd2) cmd.mem_wr = 1'b1;
      end
      ST_PIV_RD: begin
        cmd.mem_rd = 1'b1;
        if (j_r == 7'd0) begin
          j_nxt = 7'd3;
        end else begin
          cmd.mem_rd = 1'b0;
          cmd.lat_piv = 1'b1;
          i_nxt = '0; j_nxt = 7'd1;
          pl_nxt = 6'd0;
          st_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (j_r >= n_r) begin
          pa_nxt = s_r; pb_nxt = 6'(s_r + i_r);
          ret_nxt = RET_FINAL;
          st_nxt = ST_SWP_RD;
        end else begin
          k_nxt = 6'(s_r + j_r);
          st_nxt = ST_SCAN_CMP;
          pm_nxt = j_r[5:0];
          ov_fin_nxt = ov_fin_r;
        end
      end
      ST_SCAN_CMP: begin
        if (pl_r == 6'd0) begin
          cmd.mem_rd = 1'b1;
          pl_nxt = 6'd1;
        end else begin
          pl_nxt = 6'd0;
          if (sts.rd_lt_piv) begin
            pa_nxt = k_r; pb_nxt = 6'(s_r + i_r + 7'd1);
            ret_nxt = RET_SCAN;
            st_nxt = ST_SWP_RD;
          end else begin
            j_nxt = j_r + 7'd1;
            st_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_PUSH_R: begin
        if (lenr > 7'd1 && sp_r < 7'd64) begin
          stk_we = 1'b1;
          stk_wd = {lenr, 6'(s_r + i_r + 7'd1)};
          sp_nxt = sp_r + 7'd1;
        end
        st_nxt = ST_PUSH_L;
      end
      ST_PUSH_L: begin
        if (i_r > 7'd1 && sp_r < 7'd64) begin
          stk_we = 1'b1;
          stk_wd = {i_r, s_r};
          sp_nxt = sp_r + 7'd1;
        end
        st_nxt = ST_POP;
      end
      ST_OUT_RD: begin
        cmd.mem_rd = 1'b1;
        st_nxt = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        st_nxt = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          ov_val_nxt = sts.rd_data;
          ov_pos_nxt = k_r;
          ov_cmp_nxt = cmp_r;
          ov_fin_nxt = ({1'b0, k_r} + 7'd1 == cnt_r);
          if ({1'b0, k_r} + 7'd1 == cnt_r) begin
            st_nxt = ST_LOAD;
            cnt_nxt = '0;
          end else begin
            k_nxt = k_r + 6'd1;
            st_nxt = ST_OUT_RD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_LOAD) |-> in_stall)
    else $error("input taken while sorting");
  assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= 7'd64)
    else $error("range stack overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX7)
    else $error("load count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_result && !out_stall) |=> (st_r == ST_LOAD))
    else $error("batch end without return to load");

endmodule

[rtl/quicksort_with_comparison_count_top.sv]
// Top level of the quicksort block with comparison count.
// Joins qsort_ctrl and qsort_dp; uses qsort_pkg.
//
//  port group | dir | fields
//  in_        | in  | value, last
//  out_       | out | sorted_value, position, comparisons, final_result
//  cfg_       | in  | pivot_rule (write enable cfg_we)
//
// Loading accepts one item per cycle. The sort compares each element of a
// subrange with its pivot, after a setup per subrange. Each result is read
// from the element memory and loaded into the output register before the
// next is read. Input is stalled from the last item until the final result
// is loaded into the output register. rst_n is synchronous, active low.
module quicksort_with_comparison_count_top #(
  parameter int unsigned MAX_ELEMENTS = qsort_pkg::MAX_ELEM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_pivot_rule,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_sorted_value,
  output logic [5:0]                   out_position,
  output logic [10:0]                  out_comparisons,
  output logic                         out_final_result
);
  import qsort_pkg::*;

  qsort_cmd_t cmd;
  qsort_sts_t sts;
  logic       wr_load;
  logic [5:0] load_adr, adr_a, adr_b, adr_idx;
  logic [VAL_W-1:0] val_u;

  qsort_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_pivot_rule, .in_valid, .in_stall, .in_last,
    .wr_load, .load_adr, .cmd, .adr_a, .adr_b, .adr_idx, .sts,
    .out_valid, .out_stall, .out_sorted_value(val_u), .out_position,
    .out_comparisons, .out_final_result
  );

  qsort_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk, .wr_load, .load_adr, .load_data(in_value), .cmd,
    .adr_a, .adr_b, .adr_idx, .sts
  );

  assign out_sorted_value = val_u;

endmodule

[tb/sv/quicksort_with_comparison_count_top_tb.sv]
// Testbench for quicksort_with_comparison_count_top: loads batches of signed values,
// predicts sorted order and comparison totals, and checks every emitted element.
// Depends on qsort_pkg and the RTL top level only.
`timescale 1ns / 100ps

module quicksort_with_comparison_count_top_tb;
  import qsort_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         position;
    logic [10:0]        comparisons;
    logic               final_result;
  } sorted_elem_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               has_exp;
    logic [10:0]        exp_count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_pivot_rule = RULE_MEDIAN;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_sorted_value;
  logic [5:0] out_position;
  logic [10:0] out_comparisons;
  logic out_final_result;

  quicksort_with_comparison_count_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_pivot_rule(cfg_pivot_rule),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_sorted_value(out_sorted_value),
    .out_position(out_position), .out_comparisons(out_comparisons),
    .out_final_result(out_final_result)
  );

  always #5 clk = ~clk;

  logic signed [31:0] batch_store [CAP];
  int unsigned batch_len = 0;
  logic [1:0] pivot_sel = RULE_MEDIAN;
  logic [10:0] comparison_sum;
  sorted_elem_t sorted_q [$];
  // one entry per directed batch: top bit marks a typed-in total
  logic [11:0] pinned_count_q [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void swap_elems(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = batch_store[a];
    batch_store[a] = batch_store[b];
    batch_store[b] = t;
  endfunction

  function automatic void bring_pivot_to_head(int unsigned s, int unsigned n);
    int unsigned m, l, pos;
    logic signed [31:0] a, b, c;
    l = s + n - 1;
    if (pivot_sel == RULE_FIRST) return;
    if (pivot_sel == RULE_LAST) begin
      swap_elems(s, l);
      return;
    end
    m = s + (n + 1) / 2 - 1;
    a = batch_store[s];
    b = batch_store[m];
    c = batch_store[l];
    if ((a >= b || a >= c) && (b >= a || c >= a)) pos = s;
    else if ((b >= a || b >= c) && (a >= b || c >= b)) pos = m;
    else pos = l;
    swap_elems(s, pos);
  endfunction

  // sort the loaded batch and queue one expected element per position
  function automatic void sort_batch();
    int unsigned lo_stk [CAP];
    int unsigned len_stk [CAP];
    int unsigned depth;
    int unsigned s, n, i, j;
    logic signed [31:0] piv;
    sorted_elem_t e;
    comparison_sum = '0;
    depth = 0;
    if (batch_len > 1) begin
      lo_stk[0] = 0;
      len_stk[0] = batch_len;
      depth = 1;
    end
    while (depth > 0) begin
      depth--;
      s = lo_stk[depth];
      n = len_stk[depth];
      comparison_sum = comparison_sum + 11'(n - 1);
      bring_pivot_to_head(s, n);
      piv = batch_store[s];
      i = 0;
      for (j = 1; j < n; j++) begin
        if (batch_store[s + j] < piv) begin
          swap_elems(s + j, s + i + 1);
          i++;
        end
      end
      swap_elems(s, s + i);
      if (n - i - 1 > 1) begin
        lo_stk[depth] = s + i + 1;
        len_stk[depth] = n - i - 1;
        depth++;
      end
      if (i > 1) begin
        lo_stk[depth] = s;
        len_stk[depth] = i;
        depth++;
      end
    end
    for (int unsigned k = 0; k < batch_len; k++) begin
      e = '{batch_store[k], 6'(k), comparison_sum, k + 1 == batch_len};
      sorted_q.insert(sorted_q.size(), e);
    end
    batch_len = 0;
  endfunction

  function automatic void take_item(logic signed [31:0] v, logic lst);
    if (batch_len < CAP) begin
      batch_store[batch_len] = v;
      batch_len++;
    end
    if (lst) sort_batch();
  endfunction

  // result side: stall at random and check each element
  always @(posedge clk) begin
    sorted_elem_t exp;
    logic [11:0] pin;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected element value=%0d", out_sorted_value);
        fail_count++;
      end else begin
        exp = sorted_q.pop_front();
        if (out_sorted_value !== exp.value) begin
          $error("sorted_value expected %0d got %0d", exp.value, out_sorted_value);
          fail_count++;
        end
        if (out_position !== exp.position) begin
          $error("position expected %0d got %0d", exp.position, out_position);
          fail_count++;
        end
        if (out_comparisons !== exp.comparisons) begin
          $error("comparisons expected %0d got %0d", exp.comparisons, out_comparisons);
          fail_count++;
        end
        if (out_final_result !== exp.final_result) begin
          $error("final_result expected %0d got %0d", exp.final_result, out_final_result);
          fail_count++;
        end
        if (exp.final_result && pinned_count_q.size() > 0) begin
          pin = pinned_count_q.pop_front();
          if (pin[11] && out_comparisons !== pin[10:0]) begin
            $error("comparisons expected %0d got %0d", pin[10:0], out_comparisons);
            fail_count++;
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(logic signed [31:0] v, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_item(v, lst);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sorted_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_pivot_rule(logic [1:0] r);
    cfg_we <= 1'b1;
    cfg_pivot_rule <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    pivot_sel = (r == 2'd3) ? RULE_MEDIAN : r;
  endtask

  task automatic send_batch(int unsigned n, int unsigned mode);
    logic signed [31:0] v;
    for (int unsigned k = 0; k < n; k++) begin
      case (mode)
        0: v = $urandom();
        1: v = $signed(32'($urandom_range(7))) - 4;
        2: v = 32'(k) * 3 - 50;
        default: v = 32'(n - k) * 1000;
      endcase
      send_item(v, k + 1 == n);
    end
  endtask

  stim_row_t directed_rows [] = '{
    '{32'sh7fffffff, 1'b1, 1'b1, 11'd0},
    '{32'sh80000000, 1'b0, 1'b0, 11'd0},
    '{32'sh7fffffff, 1'b1, 1'b1, 11'd1},
    '{32'sd5,        1'b0, 1'b0, 11'd0},
    '{-32'sd3,       1'b0, 1'b0, 11'd0},
    '{32'sd0,        1'b0, 1'b0, 11'd0},
    '{32'sh80000000, 1'b0, 1'b0, 11'd0},
    '{32'sd5,        1'b1, 1'b0, 11'd0},
    '{32'sd2,        1'b0, 1'b0, 11'd0},
    '{32'sd2,        1'b0, 1'b0, 11'd0},
    '{32'sd2,        1'b1, 1'b0, 11'd0},
    '{32'sh55555555, 1'b0, 1'b0, 11'd0},
    '{32'shaaaaaaaa, 1'b1, 1'b1, 11'd1}
  };

  initial begin
    int unsigned phase_idle [4] = '{0, 56, 0, 15};
    int unsigned phase_stall [4] = '{0, 0, 56, 15};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].last)
        pinned_count_q.insert(pinned_count_q.size(),
                              {directed_rows[r].has_exp, directed_rows[r].exp_count});
      send_item(directed_rows[r].value, directed_rows[r].last);
    end
    drain_results();

    // full store: the items that find the store full are dropped
    set_pivot_rule(RULE_FIRST);
    send_batch(66, 2);
    drain_results();
    set_pivot_rule(RULE_LAST);
    send_batch(10, 3);
    drain_results();
    set_pivot_rule(2'd3);
    send_batch(5, 1);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int b = 0; b < 3; b++) begin
        set_pivot_rule(2'($urandom_range(3)));
        send_batch($urandom_range(1, 10), $urandom_range(2));
        drain_results();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/qsort_pkg.sv
rtl/qsort_dp.sv
rtl/qsort_ctrl.sv
rtl/quicksort_with_comparison_count_top.sv
tb/sv/quicksort_with_comparison_count_top_tb.sv
